// ----- rtl/blpg_pkg.sv -----
// Shared constants and types for the line pixel generator.
package blpg_pkg;

   // Field widths fixed by the register map and the pixel format.
   localparam int OFFSET_BITS      = 12;
   localparam int BPX_BITS         = 4;
   localparam int BPY_BITS         = 16;
   localparam int COLOR_BITS       = 24;
   localparam int BYTE_OFFSET_BITS = 32;
   localparam int CSR_DATA_BITS    = 24;
   localparam int CSR_INDEX_BITS   = 3;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   // Register indexes.
   localparam csr_index_type CSR_X_OFFSET    = 3'd0;
   localparam csr_index_type CSR_Y_OFFSET    = 3'd1;
   localparam csr_index_type CSR_BYTES_PER_X = 3'd2;
   localparam csr_index_type CSR_BYTES_PER_Y = 3'd3;
   localparam csr_index_type CSR_LINE_COLOR  = 3'd4;

   // Register reset values; the color is light gray (225, 225, 225).
   localparam logic [OFFSET_BITS-1:0] X_OFFSET_RESET    = 12'd0;
   localparam logic [OFFSET_BITS-1:0] Y_OFFSET_RESET    = 12'd0;
   localparam logic [BPX_BITS-1:0]    BYTES_PER_X_RESET = 4'd4;
   localparam logic [BPY_BITS-1:0]    BYTES_PER_Y_RESET = 16'd4096;
   localparam logic [COLOR_BITS-1:0]  LINE_COLOR_RESET  = 24'hE1E1E1;

   // Command codes.
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

endpackage

// ----- rtl/blpg_if.sv -----
// Request and result channel interfaces of the line pixel generator.
interface blpg_req_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [COORD_BITS-1:0] x_start;
   logic [COORD_BITS-1:0] x_end;
   logic [COORD_BITS-1:0] y_start;
   logic [COORD_BITS-1:0] y_end;

   modport source (
      output valid, command, x_start, x_end, y_start, y_end,
      input  ready
   );
   modport sink (
      input  valid, command, x_start, x_end, y_start, y_end,
      output ready
   );
endinterface

interface blpg_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                                  valid;
   logic                                  ready;
   logic [COORD_BITS-1:0]                 pixel_x;
   logic [COORD_BITS-1:0]                 pixel_y;
   logic [blpg_pkg::BYTE_OFFSET_BITS-1:0] byte_offset;
   logic [blpg_pkg::COLOR_BITS-1:0]       pixel_word;
   logic                                  last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, byte_offset, pixel_word, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, byte_offset, pixel_word, last_pixel,
      output ready
   );
endinterface

// ----- rtl/bresenham_line_pixel_generator_top.sv -----
// Top level of the Bresenham line pixel generator.
//
// Usage: a start item (command 0) loads both endpoints and yields the first
// pixel of the line. Each advance item (command 1) takes one Bresenham step
// and yields the next pixel. An advance item while no line is active is
// consumed and yields no item. A start item during a running line abandons
// it. The pixel with last_pixel set is the end point; the line then goes idle.
// Each result item carries the coordinates, the framebuffer byte offset
// (x + x_offset) * bytes_per_x + (y + y_offset) * bytes_per_y modulo 2^32,
// and the 24-bit 0xRRGGBB color word from the line_color register.
// The user must write registers through the csr_ port only while no item is
// in flight; the block does not enforce this. The step logic, the two offset
// multipliers, and the final 32-bit add each take one stage. Throughput is
// one item per cycle while the receiver does not stall; the step loop closes
// through one register stage, so consecutive advance items can follow back
// to back. Every stage holds its item while the stage after it is full, so
// when the receiver stalls the pipeline fills and req_chan.ready drops only
// once all three stages hold results. Reset is synchronous; it empties the
// pipeline, leaves the line idle and restores the register defaults.
module bresenham_line_pixel_generator_top #(
   parameter int COORD_BITS = 12
) (
   input  logic                                       clock,
   input  logic                                       reset,
   blpg_req_if.sink                                   req_chan,
   blpg_rsp_if.source                                 rsp_chan,
   input  logic                                       csr_write_en,
   input  blpg_pkg::csr_index_type                    csr_index,
   input  logic [blpg_pkg::CSR_DATA_BITS-1:0]         csr_write_data
);

   // Error term is two bits wider than a coordinate; the doubled error test
   // is evaluated one bit wider still.
   localparam int ERR_BITS = COORD_BITS + 2;
   localparam int EXT_BITS = COORD_BITS + 3;
   // Width of a coordinate plus its panning offset.
   localparam int SUM_BITS =
      ((COORD_BITS > blpg_pkg::OFFSET_BITS) ? COORD_BITS : blpg_pkg::OFFSET_BITS) + 1;
   localparam int PX_BITS  = SUM_BITS + blpg_pkg::BPX_BITS;
   localparam int PY_BITS  = SUM_BITS + blpg_pkg::BPY_BITS;
   localparam int OFS_BITS = blpg_pkg::BYTE_OFFSET_BITS;

   // Configuration registers.
   logic [blpg_pkg::OFFSET_BITS-1:0] x_offset_ff, y_offset_ff;
   logic [blpg_pkg::BPX_BITS-1:0]    bytes_per_x_ff;
   logic [blpg_pkg::BPY_BITS-1:0]    bytes_per_y_ff;
   logic [blpg_pkg::COLOR_BITS-1:0]  line_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff    <= blpg_pkg::X_OFFSET_RESET;
         y_offset_ff    <= blpg_pkg::Y_OFFSET_RESET;
         bytes_per_x_ff <= blpg_pkg::BYTES_PER_X_RESET;
         bytes_per_y_ff <= blpg_pkg::BYTES_PER_Y_RESET;
         line_color_ff  <= blpg_pkg::LINE_COLOR_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            blpg_pkg::CSR_X_OFFSET: begin
               x_offset_ff <= csr_write_data[blpg_pkg::OFFSET_BITS-1:0];
            end
            blpg_pkg::CSR_Y_OFFSET: begin
               y_offset_ff <= csr_write_data[blpg_pkg::OFFSET_BITS-1:0];
            end
            blpg_pkg::CSR_BYTES_PER_X: begin
               bytes_per_x_ff <= csr_write_data[blpg_pkg::BPX_BITS-1:0];
            end
            blpg_pkg::CSR_BYTES_PER_Y: begin
               bytes_per_y_ff <= csr_write_data[blpg_pkg::BPY_BITS-1:0];
            end
            blpg_pkg::CSR_LINE_COLOR: begin
               line_color_ff <= csr_write_data[blpg_pkg::COLOR_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Line state.
   logic [COORD_BITS-1:0]      cur_x_ff, cur_y_ff, end_x_ff, end_y_ff;
   logic [COORD_BITS-1:0]      delta_x_ff, delta_y_ff;
   logic signed [ERR_BITS-1:0] error_term_ff;
   logic                       step_x_neg_ff, step_y_neg_ff, line_active_ff;

   logic [COORD_BITS-1:0]      cur_x_in, cur_y_in, end_x_in, end_y_in;
   logic [COORD_BITS-1:0]      delta_x_in, delta_y_in;
   logic signed [ERR_BITS-1:0] error_term_in;
   logic                       step_x_neg_in, step_y_neg_in;

   // Pipeline stage registers.
   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [COORD_BITS-1:0] s1_x_ff, s1_y_ff, s2_x_ff, s2_y_ff, s3_x_ff, s3_y_ff;
   logic                  s1_last_ff, s2_last_ff, s3_last_ff;
   logic [OFS_BITS-1:0]   s2_ox_ff, s2_oy_ff, s3_offset_ff;
   logic [blpg_pkg::COLOR_BITS-1:0] s3_word_ff;

   // Stage load enables: a stage takes a new item when it is empty or when
   // its current item moves on in this cycle.
   logic s3_ready, s2_ready, s1_ready, req_fire;

   assign s3_ready = !s3_valid_ff || rsp_chan.ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;
   assign req_fire = req_chan.valid && s1_ready;

   // Start command: deltas and the initial error term.
   logic [COORD_BITS-1:0]      st_dx, st_dy;
   logic signed [EXT_BITS-1:0] st_err;

   always_comb begin
      st_dx = (req_chan.x_end >= req_chan.x_start) ?
              req_chan.x_end - req_chan.x_start : req_chan.x_start - req_chan.x_end;
      st_dy = (req_chan.y_end >= req_chan.y_start) ?
              req_chan.y_end - req_chan.y_start : req_chan.y_start - req_chan.y_end;
      st_err = signed'(EXT_BITS'(st_dx)) - signed'(EXT_BITS'(st_dy));
   end

   // Advance command: one step with the doubled-error test.
   logic signed [EXT_BITS-1:0] err_ext, e2, dx_ext, dy_ext, adv_err;
   logic                       take_x, take_y;
   logic [COORD_BITS-1:0]      adv_x, adv_y;

   always_comb begin
      err_ext = EXT_BITS'(error_term_ff);
      e2      = err_ext <<< 1;
      dx_ext  = signed'(EXT_BITS'(delta_x_ff));
      dy_ext  = signed'(EXT_BITS'(delta_y_ff));
      take_x  = e2 > -dy_ext;
      take_y  = e2 < dx_ext;
      adv_err = err_ext;
      adv_x   = cur_x_ff;
      adv_y   = cur_y_ff;
      if (take_x) begin
         adv_err = adv_err - dy_ext;
         adv_x   = step_x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
      end
      if (take_y) begin
         adv_err = adv_err + dx_ext;
         adv_y   = step_y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
      end
   end

   // Next state and the pixel that goes into the first stage.
   logic is_start, produce, new_last;

   always_comb begin
      is_start      = req_chan.command == blpg_pkg::CMD_START;
      produce       = is_start || line_active_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      delta_x_in    = delta_x_ff;
      delta_y_in    = delta_y_ff;
      error_term_in = error_term_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      if (is_start) begin
         cur_x_in      = req_chan.x_start;
         cur_y_in      = req_chan.y_start;
         end_x_in      = req_chan.x_end;
         end_y_in      = req_chan.y_end;
         delta_x_in    = st_dx;
         delta_y_in    = st_dy;
         error_term_in = ERR_BITS'(st_err);
         step_x_neg_in = !(req_chan.x_start < req_chan.x_end);
         step_y_neg_in = !(req_chan.y_start < req_chan.y_end);
      end else begin
         cur_x_in      = adv_x;
         cur_y_in      = adv_y;
         error_term_in = ERR_BITS'(adv_err);
      end
      new_last = (cur_x_in == end_x_in) && (cur_y_in == end_y_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         end_x_ff       <= '0;
         end_y_ff       <= '0;
         delta_x_ff     <= '0;
         delta_y_ff     <= '0;
         error_term_ff  <= '0;
         step_x_neg_ff  <= 1'b0;
         step_y_neg_ff  <= 1'b0;
         line_active_ff <= 1'b0;
      end else if (req_fire && produce) begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         end_x_ff       <= end_x_in;
         end_y_ff       <= end_y_in;
         delta_x_ff     <= delta_x_in;
         delta_y_ff     <= delta_y_in;
         error_term_ff  <= error_term_in;
         step_x_neg_ff  <= step_x_neg_in;
         step_y_neg_ff  <= step_y_neg_in;
         line_active_ff <= !new_last;
      end
   end

   // Stage two operands: coordinates plus panning offsets, then the products.
   logic [SUM_BITS-1:0] sum_x, sum_y;
   logic [PX_BITS-1:0]  prod_x;
   logic [PY_BITS-1:0]  prod_y;

   always_comb begin
      sum_x  = SUM_BITS'(s1_x_ff) + SUM_BITS'(x_offset_ff);
      sum_y  = SUM_BITS'(s1_y_ff) + SUM_BITS'(y_offset_ff);
      prod_x = PX_BITS'(sum_x) * PX_BITS'(bytes_per_x_ff);
      prod_y = PY_BITS'(sum_y) * PY_BITS'(bytes_per_y_ff);
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_fire && produce;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_x_ff    <= cur_x_in;
         s1_y_ff    <= cur_y_in;
         s1_last_ff <= new_last;
      end
      if (s2_ready) begin
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_last_ff <= s1_last_ff;
         s2_ox_ff   <= OFS_BITS'(prod_x);
         s2_oy_ff   <= OFS_BITS'(prod_y);
      end
      if (s3_ready) begin
         s3_x_ff      <= s2_x_ff;
         s3_y_ff      <= s2_y_ff;
         s3_last_ff   <= s2_last_ff;
         s3_offset_ff <= s2_ox_ff + s2_oy_ff;
         s3_word_ff   <= line_color_ff;
      end
   end

   assign rsp_chan.valid       = s3_valid_ff;
   assign rsp_chan.pixel_x     = s3_x_ff;
   assign rsp_chan.pixel_y     = s3_y_ff;
   assign rsp_chan.byte_offset = s3_offset_ff;
   assign rsp_chan.pixel_word  = s3_word_ff;
   assign rsp_chan.last_pixel  = s3_last_ff;

   // A start item always yields a pixel.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.command == blpg_pkg::CMD_START) |=> s1_valid_ff)
      else $error("start item produced no pixel");

   // An advance item while idle yields nothing and leaves the position alone.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.command == blpg_pkg::CMD_ADVANCE) && !line_active_ff
      |=> !s1_valid_ff && $stable(cur_x_ff) && $stable(cur_y_ff))
      else $error("advance while idle changed state or produced a pixel");

   // The line stays active exactly until its end point has been produced.
   assert property (@(posedge clock) disable iff (reset)
      $past(req_fire && !reset) && s1_valid_ff |-> line_active_ff == !s1_last_ff)
      else $error("line activity disagrees with the last pixel flag");

   // The input stalls only when every stage is full and the receiver is stalled.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && !rsp_chan.ready)
      else $error("input stalled while the pipeline had room");

endmodule
